>>> hw/rtl/mcst_pkg.sv
`timescale 1ns / 1ps

package mcst_pkg;

  // Queue between the parser and the state tracker
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // MIDI byte codes
  localparam logic [7:0] REALTIME_MIN = 8'hF8;
  localparam logic [7:0] SYSEX_START  = 8'hF0;
  localparam logic [7:0] SYSEX_END    = 8'hF7;
  localparam logic [7:0] NO_STATUS    = 8'h00;

  // Upper nibble of a channel status byte, and the lower nibble for channel 1
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_CTRL     = 4'hB;
  localparam logic [3:0] KIND_PROG     = 4'hC;
  localparam logic [3:0] KIND_PRESS    = 4'hD;
  localparam logic [3:0] CHANNEL_ONE   = 4'h0;

  // Data bytes a message needs
  localparam logic [1:0] WANT_NONE = 2'd0;
  localparam logic [1:0] WANT_ONE  = 2'd1;
  localparam logic [1:0] WANT_TWO  = 2'd2;

  localparam logic [6:0] CTRL_WHEEL  = 7'd1;
  localparam logic [6:0] CTRL_BRIGHT = 7'd74;
  localparam logic [6:0] NOTE_RESET  = 7'd60;
  localparam logic [6:0] VEL_ZERO    = 7'd0;

  // Action handed from the parser to the tracker, one per byte
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_NOTE_ON,
    CMD_NOTE_OFF,
    CMD_SET_WHEEL,
    CMD_SET_BRIGHT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [6:0] arg;
  } cmd_t;

endpackage

>>> hw/rtl/mcst_front.sv
`timescale 1ns / 1ps

module mcst_front import mcst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] midi_byte,
  output logic       push_valid,
  output cmd_t       push_cmd,
  input  logic       push_stall
);

  logic [7:0] status_byte, status_byte_next;
  logic [6:0] first_data, first_data_next;
  logic       data_seen, data_seen_next;
  logic [1:0] data_wanted, data_wanted_next;
  logic       sysex_open, sysex_open_next;
  logic       accept;
  logic [3:0] byte_kind;
  logic [3:0] run_kind;
  logic [6:0] data_val;

  assign accept     = in_valid && !push_stall;
  assign in_stall   = push_stall;
  assign push_valid = in_valid;
  assign byte_kind  = midi_byte[7:4];
  assign run_kind   = status_byte[7:4];
  assign data_val   = midi_byte[6:0];

  // Parse one byte: running status, sysex, data count; classify the message
  always_comb begin
    status_byte_next = status_byte;
    first_data_next  = first_data;
    data_seen_next   = data_seen;
    data_wanted_next = data_wanted;
    sysex_open_next  = sysex_open;
    push_cmd.op      = CMD_NONE;
    push_cmd.arg     = data_val;
    if (midi_byte[7]) begin
      if (midi_byte >= REALTIME_MIN) begin
        // realtime: parser untouched
      end else if (midi_byte == SYSEX_START) begin
        sysex_open_next  = 1'b1;
        status_byte_next = NO_STATUS;
        data_seen_next   = 1'b0;
        data_wanted_next = WANT_NONE;
      end else if (midi_byte == SYSEX_END) begin
        sysex_open_next  = 1'b0;
        data_seen_next   = 1'b0;
        data_wanted_next = WANT_NONE;
      end else if (sysex_open) begin
        // status inside sysex is dropped
      end else if (midi_byte >= SYSEX_START) begin
        status_byte_next = NO_STATUS;
        data_seen_next   = 1'b0;
        data_wanted_next = WANT_NONE;
      end else begin
        status_byte_next = midi_byte;
        data_seen_next   = 1'b0;
        data_wanted_next = (byte_kind == KIND_PROG || byte_kind == KIND_PRESS) ?
                           WANT_ONE : WANT_TWO;
      end
    end else if (!sysex_open && status_byte != NO_STATUS && data_wanted != WANT_NONE) begin
      if (!data_seen) begin
        first_data_next = data_val;
        data_seen_next  = (data_wanted == WANT_TWO);
      end else begin
        // second data byte completes a two-byte message
        data_seen_next = 1'b0;
        if (status_byte[3:0] == CHANNEL_ONE) begin
          if (run_kind == KIND_NOTE_ON && data_val != VEL_ZERO) begin
            push_cmd.op  = CMD_NOTE_ON;
            push_cmd.arg = first_data;
          end else if (run_kind == KIND_NOTE_ON || run_kind == KIND_NOTE_OFF) begin
            push_cmd.op  = CMD_NOTE_OFF;
            push_cmd.arg = first_data;
          end else if (run_kind == KIND_CTRL) begin
            if (first_data == CTRL_WHEEL) begin
              push_cmd.op = CMD_SET_WHEEL;
            end else if (first_data == CTRL_BRIGHT) begin
              push_cmd.op = CMD_SET_BRIGHT;
            end
          end
        end
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      status_byte <= NO_STATUS;
      first_data  <= 7'd0;
      data_seen   <= 1'b0;
      data_wanted <= WANT_NONE;
      sysex_open  <= 1'b0;
    end else if (accept) begin
      status_byte <= status_byte_next;
      first_data  <= first_data_next;
      data_seen   <= data_seen_next;
      data_wanted <= data_wanted_next;
      sysex_open  <= sysex_open_next;
    end
  end

endmodule

>>> hw/rtl/mcst_fifo.sv
`timescale 1ns / 1ps

module mcst_fifo import mcst_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  cmd_t push_cmd,
  output logic push_stall,
  output logic pop_valid,
  output cmd_t pop_cmd,
  input  logic pop_stall
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_stall = (fill == QCNT_W'(QDEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop_valid && !pop_stall;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/mcst_back.sv
`timescale 1ns / 1ps

module mcst_back import mcst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        pop_valid,
  input  cmd_t        pop_cmd,
  output logic        pop_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        note_is_active,
  output logic [6:0]  active_note,
  output logic [6:0]  previous_note,
  output logic [6:0]  mod_wheel_value,
  output logic [6:0]  brightness_value,
  output logic [31:0] note_on_total
);

  logic        holding_note;
  logic [6:0]  held_note;
  logic [6:0]  latest_note;
  logic [6:0]  wheel_reg;
  logic [6:0]  bright_reg;
  logic [31:0] note_counter;
  logic        take;

  // The tracked state is the output snapshot; it only moves when the slot frees
  assign pop_stall = out_valid && out_stall;
  assign take      = pop_valid && !pop_stall;

  assign note_is_active   = holding_note;
  assign active_note      = held_note;
  assign previous_note    = latest_note;
  assign mod_wheel_value  = wheel_reg;
  assign brightness_value = bright_reg;
  assign note_on_total    = note_counter;

  // Apply one transaction to the channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      holding_note <= 1'b0;
      held_note    <= NOTE_RESET;
      latest_note  <= NOTE_RESET;
      wheel_reg    <= 7'd0;
      bright_reg   <= 7'd0;
      note_counter <= 32'd0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        case (pop_cmd.op)
          CMD_NOTE_ON: begin
            holding_note <= 1'b1;
            held_note    <= pop_cmd.arg;
            latest_note  <= pop_cmd.arg;
            note_counter <= note_counter + 32'd1;
          end
          CMD_NOTE_OFF: begin
            if (holding_note && pop_cmd.arg == held_note) begin
              holding_note <= 1'b0;
            end
          end
          CMD_SET_WHEEL: begin
            wheel_reg <= pop_cmd.arg;
          end
          CMD_SET_BRIGHT: begin
            bright_reg <= pop_cmd.arg;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

>>> hw/rtl/midi_channel_state_tracker_unit.sv
// An accepted byte is written into the command queue; the tracker then registers its snapshot.
// Throughput: one byte per cycle while the 4-entry command queue has room; the parser passes its
// stall to the input and the tracker owns the output handshake, so the two stall independently.
// Reset (rst, synchronous, active high): no running status, sysex closed, no note held,
// both note numbers 60, controller values and note count zero, queue empty.
`timescale 1ns / 1ps

module midi_channel_state_tracker_unit import mcst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  midi_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        note_is_active,
  output logic [6:0]  active_note,
  output logic [6:0]  previous_note,
  output logic [6:0]  mod_wheel_value,
  output logic [6:0]  brightness_value,
  output logic [31:0] note_on_total
);

  logic push_valid;
  cmd_t push_cmd;
  logic push_stall;
  logic pop_valid;
  cmd_t pop_cmd;
  logic pop_stall;

  // Byte parser
  mcst_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .midi_byte  (midi_byte),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_stall (push_stall)
  );

  // Command queue
  mcst_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_stall (push_stall),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_stall  (pop_stall)
  );

  // Channel state tracker
  mcst_back u_back (
    .clk              (clk),
    .rst              (rst),
    .pop_valid        (pop_valid),
    .pop_cmd          (pop_cmd),
    .pop_stall        (pop_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .note_is_active   (note_is_active),
    .active_note      (active_note),
    .previous_note    (previous_note),
    .mod_wheel_value  (mod_wheel_value),
    .brightness_value (brightness_value),
    .note_on_total    (note_on_total)
  );

endmodule

>>> hw/rtl/mcst_checker.sv
`timescale 1ns / 1ps

module mcst_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        note_is_active,
  input logic [6:0]  active_note,
  input logic [6:0]  previous_note,
  input logic [31:0] note_on_total
);

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(note_on_total) && $stable(active_note))
    else $error("stalled result changed");

  // No result right out of reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Note count moves by at most one per cycle
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (note_on_total == $past(note_on_total) ||
                     note_on_total == $past(note_on_total) + 32'd1))
    else $error("note count jumped");

  // A counted note-on leaves a held note
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && note_on_total != $past(note_on_total) |-> note_is_active)
    else $error("note count moved without a held note");

  // While a note is held, both note numbers agree
  assert property (@(posedge clk) disable iff (rst)
    note_is_active |-> active_note == previous_note)
    else $error("held note and last note differ");

endmodule

bind midi_channel_state_tracker_unit mcst_checker u_mcst_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .note_is_active (note_is_active),
  .active_note    (active_note),
  .previous_note  (previous_note),
  .note_on_total  (note_on_total)
);

>>> bench/midi_channel_state_tracker_unit_tb.sv
`timescale 1ns / 1ps

module midi_channel_state_tracker_unit_tb;
  import mcst_pkg::*;

  // One output snapshot, field order as on the ports
  typedef struct packed {
    logic        active;
    logic [6:0]  note;
    logic [6:0]  prev;
    logic [6:0]  wheel;
    logic [6:0]  bright;
    logic [31:0] total;
  } snap_t;

  // One stimulus byte, with a hand-written expectation where one is given
  typedef struct packed {
    logic [7:0] b;
    logic       fixed;
    snap_t      want;
  } row_t;

  localparam snap_t AT_RESET  = '{1'b0, NOTE_RESET, NOTE_RESET, 7'd0, 7'd0, 32'd0};
  localparam snap_t TOP_NOTE  = '{1'b1, 7'd127, 7'd127, 7'd0, 7'd0, 32'd1};
  localparam snap_t NO_FIX    = '0;
  localparam int    N_ROWS    = 25;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  midi_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        note_is_active;
  logic [6:0]  active_note;
  logic [6:0]  previous_note;
  logic [6:0]  mod_wheel_value;
  logic [6:0]  brightness_value;
  logic [31:0] note_on_total;

  midi_channel_state_tracker_unit DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .midi_byte        (midi_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .note_is_active   (note_is_active),
    .active_note      (active_note),
    .previous_note    (previous_note),
    .mod_wheel_value  (mod_wheel_value),
    .brightness_value (brightness_value),
    .note_on_total    (note_on_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser and channel state as this bench tracks it
  logic [7:0]  run_status;
  logic [6:0]  first_arg, second_arg;
  logic [1:0]  data_count, data_need;
  logic        in_sysex, note_held;
  logic [6:0]  held_num, last_num, wheel_val, bright_val;
  logic [31:0] note_count;

  row_t  pending_rows[$];
  snap_t expected_snaps[$];
  int    errors = 0;
  int    results_checked = 0;
  int    bytes_sent = 0;
  int    stall_cycles = 0;
  int    sysex_blocks = 0;
  int    send_pct = 23;
  int    recv_pct = 56;
  int    phase = 0;
  int    hold_left = 0;
  bit    hold_done = 1'b0;
  logic [7:0] last_status = NO_STATUS;

  // Apply one completed two-data-byte message
  task automatic apply_message();
    logic [3:0] kind;
    kind = run_status[7:4];
    if (run_status[3:0] == CHANNEL_ONE) begin
      if (kind == KIND_NOTE_ON && second_arg != VEL_ZERO) begin
        note_held  = 1'b1;
        held_num   = first_arg;
        last_num   = first_arg;
        note_count = note_count + 32'd1;
      end else if (kind == KIND_NOTE_ON || kind == KIND_NOTE_OFF) begin
        if (note_held && first_arg == held_num) note_held = 1'b0;
      end else if (kind == KIND_CTRL) begin
        if (first_arg == CTRL_WHEEL) wheel_val = second_arg;
        else if (first_arg == CTRL_BRIGHT) bright_val = second_arg;
      end
    end
  endtask

  // Take one byte into the tracked parser state
  task automatic track_byte(input logic [7:0] b);
    if (b[7]) begin
      if (b >= REALTIME_MIN) begin
        // realtime: nothing moves
      end else if (b == SYSEX_START) begin
        in_sysex   = 1'b1;
        run_status = NO_STATUS;
        data_count = 2'd0;
        data_need  = WANT_NONE;
      end else if (b == SYSEX_END) begin
        in_sysex   = 1'b0;
        data_count = 2'd0;
        data_need  = WANT_NONE;
      end else if (in_sysex) begin
        // status inside sysex is dropped
      end else if (b >= SYSEX_START) begin
        run_status = NO_STATUS;
        data_count = 2'd0;
        data_need  = WANT_NONE;
      end else begin
        run_status = b;
        data_count = 2'd0;
        data_need  = (b[7:4] == KIND_PROG || b[7:4] == KIND_PRESS) ? WANT_ONE : WANT_TWO;
      end
    end else if (!in_sysex && run_status != NO_STATUS && data_need != WANT_NONE) begin
      if (data_count == 2'd0) begin
        first_arg  = b[6:0];
        data_count = 2'd1;
      end else if (data_count == 2'd1) begin
        second_arg = b[6:0];
        data_count = 2'd2;
      end
      if (data_count >= data_need) begin
        if (data_need == WANT_TWO) apply_message();
        data_count = 2'd0;
      end
    end
  endtask

  // Input acceptance feeds the tracker; output acceptance is checked
  always @(posedge clk) begin : watch
    row_t  row;
    snap_t seen, want;
    if (!rst) begin
      if (in_valid && in_stall) stall_cycles++;
      if (in_valid && !in_stall) begin
        row = pending_rows.pop_front();
        track_byte(row.b);
        expected_snaps.push_back(row.fixed ? row.want :
          snap_t'{note_held, held_num, last_num, wheel_val, bright_val, note_count});
      end
      if (out_valid && !out_stall) begin
        seen = '{note_is_active, active_note, previous_note, mod_wheel_value,
                 brightness_value, note_on_total};
        if (expected_snaps.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected snapshot at %0t", $realtime);
        end else begin
          want = expected_snaps.pop_front();
          if (seen.active !== want.active || seen.note !== want.note ||
              seen.prev !== want.prev || seen.wheel !== want.wheel ||
              seen.bright !== want.bright || seen.total !== want.total) begin
            errors++;
            if (errors <= 10)
              $display("Snapshot %0d wrong: exp act=%0d note=%0d prev=%0d wh=%0d br=%0d n=%0d",
                       results_checked, want.active, want.note, want.prev, want.wheel,
                       want.bright, want.total,
                       " / got act=%0d note=%0d prev=%0d wh=%0d br=%0d n=%0d",
                       seen.active, seen.note, seen.prev, seen.wheel, seen.bright,
                       seen.total);
          end
          results_checked++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off in the quiet phase
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (phase == 2 && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= 59;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_pct);
    end
  end

  // Offer one byte and wait for it to be taken; returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic fixed, input snap_t want);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    pending_rows.push_back('{b, fixed, want});
    in_valid  <= 1'b1;
    midi_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Random byte with the odd realtime byte slipped in ahead of it
  task automatic put(input logic [7:0] b);
    if ($urandom_range(0, 99) < 4)
      send_byte(REALTIME_MIN + 8'($urandom_range(0, 7)), 1'b0, NO_FIX);
    send_byte(b, 1'b0, NO_FIX);
  endtask

  // Status byte, left out now and then to lean on running status
  task automatic put_status(input logic [7:0] status);
    if (status != last_status || $urandom_range(0, 1) == 0) put(status);
    last_status = status;
  endtask

  function automatic logic [7:0] data_byte();
    return 8'($urandom_range(0, 127));
  endfunction

  // One random message, mostly well formed and mostly on channel 1
  task automatic send_message();
    int pick, n;
    logic [6:0] note, ctrl;
    pick = $urandom_range(0, 99);
    note = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) :
                                         7'(56 + $urandom_range(0, 7));
    if (pick < 30) begin
      put_status({KIND_NOTE_ON, CHANNEL_ONE});
      put({1'b0, note});
      put(($urandom_range(0, 99) < 20) ? {1'b0, VEL_ZERO} : 8'($urandom_range(1, 127)));
    end else if (pick < 45) begin
      put_status({KIND_NOTE_OFF, CHANNEL_ONE});
      put({1'b0, note});
      put(data_byte());
    end else if (pick < 60) begin
      n = $urandom_range(0, 2);
      ctrl = (n == 0) ? CTRL_WHEEL : (n == 1) ? CTRL_BRIGHT : 7'($urandom_range(0, 127));
      put_status({KIND_CTRL, CHANNEL_ONE});
      put({1'b0, ctrl});
      put(data_byte());
    end else if (pick < 67) begin
      // one-data-byte kinds, sometimes repeated under running status
      put_status({($urandom_range(0, 1) == 0) ? KIND_PROG : KIND_PRESS,
                  4'($urandom_range(0, 15))});
      put(data_byte());
      if ($urandom_range(0, 1) == 0) put(data_byte());
    end else if (pick < 80) begin
      // any kind on any channel, aftertouch and pitch bend included
      put_status({4'($urandom_range(KIND_NOTE_OFF, KIND_PRESS + 1)),
                  4'($urandom_range(0, 15))});
      put({1'b0, note});
      put(data_byte());
    end else if (pick < 87) begin
      sysex_blocks++;
      put(SYSEX_START);
      n = $urandom_range(0, 6);
      repeat (n) begin
        case ($urandom_range(0, 9))
          0: put(8'($urandom_range(128, 246)));
          1: put(SYSEX_START);
          default: put(data_byte());
        endcase
      end
      if ($urandom_range(0, 9) != 0) put(SYSEX_END);
      last_status = NO_STATUS;
    end else if (pick < 92) begin
      put(SYSEX_START + 8'($urandom_range(1, 6)));
      if ($urandom_range(0, 1) == 0) put(data_byte());
      last_status = NO_STATUS;
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) put(8'($urandom_range(0, 255)));
      last_status = NO_STATUS;
    end
  endtask

  // Directed bytes; expectations typed in only where they are obvious
  row_t directed_rows [N_ROWS] = '{
    '{REALTIME_MIN, 1'b1, AT_RESET},                 // realtime right after reset
    '{8'h45, 1'b1, AT_RESET},                        // data with no running status
    '{{KIND_NOTE_ON, CHANNEL_ONE}, 1'b1, AT_RESET},
    '{8'h7F, 1'b1, AT_RESET},                        // top note, message half done
    '{8'h7F, 1'b1, TOP_NOTE},                        // top velocity completes it
    '{8'h00, 1'b0, NO_FIX},                          // running status, note 0
    '{8'h00, 1'b0, NO_FIX},                          // velocity 0: off, wrong note
    '{{KIND_NOTE_OFF, CHANNEL_ONE}, 1'b0, NO_FIX},
    '{8'h7F, 1'b0, NO_FIX},
    '{8'h00, 1'b0, NO_FIX},                          // off on the held note
    '{{KIND_CTRL, CHANNEL_ONE}, 1'b0, NO_FIX},
    '{{1'b0, CTRL_WHEEL}, 1'b0, NO_FIX},
    '{8'h7F, 1'b0, NO_FIX},
    '{{1'b0, CTRL_BRIGHT}, 1'b0, NO_FIX},            // running status controller
    '{8'hFE, 1'b0, NO_FIX},                          // realtime inside a message
    '{8'h7F, 1'b0, NO_FIX},
    '{{KIND_PROG, CHANNEL_ONE}, 1'b0, NO_FIX},
    '{8'h05, 1'b0, NO_FIX},
    '{SYSEX_START, 1'b0, NO_FIX},
    '{{KIND_NOTE_ON, 4'h3}, 1'b0, NO_FIX},           // status inside sysex
    '{SYSEX_START, 1'b0, NO_FIX},                    // sysex opened twice
    '{SYSEX_END, 1'b0, NO_FIX},
    '{SYSEX_END, 1'b0, NO_FIX},                      // close with nothing open
    '{SYSEX_START + 8'd1, 1'b0, NO_FIX},             // system common
    '{8'h22, 1'b0, NO_FIX}                           // data after running status cleared
  };

  // Main sequence
  initial begin
    run_status = NO_STATUS;
    first_arg  = 7'd0;
    second_arg = 7'd0;
    data_count = 2'd0;
    data_need  = WANT_NONE;
    in_sysex   = 1'b0;
    note_held  = 1'b0;
    held_num   = NOTE_RESET;
    last_num   = NOTE_RESET;
    wheel_val  = 7'd0;
    bright_val = 7'd0;
    note_count = 32'd0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < N_ROWS; i++)
      send_byte(directed_rows[i].b, directed_rows[i].fixed, directed_rows[i].want);

    while (bytes_sent < 670) send_message();
    send_pct = 56;
    recv_pct = 23;
    phase = 1;
    while (bytes_sent < 1310) send_message();
    send_pct = 0;
    recv_pct = 0;
    phase = 2;
    while (bytes_sent < 1950) send_message();
    in_valid <= 1'b0;

    while (expected_snaps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d MIDI bytes (%0d directed), %0d snapshots checked, %0d sysex blocks",
             bytes_sent, N_ROWS, results_checked, sysex_blocks);
    $display("Note-ons counted: %0d; cycles with input held off: %0d",
             note_count, stall_cycles);
    if (errors == 0 && expected_snaps.size() == 0) begin
      $display("midi_channel_state_tracker_unit test passed");
    end else begin
      $display("Errors: %0d, snapshots still owed: %0d", errors, expected_snaps.size());
      $display("midi_channel_state_tracker_unit test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timed out with %0d snapshots still owed", expected_snaps.size());
    $display("midi_channel_state_tracker_unit test failed");
    $finish;
  end

endmodule
